FILE: design/cwt_pkg.sv
// ============================================================================
// cwt_pkg: shared types and constants of the conflict witness table
// Holds the request codes, the scan accumulator that travels along the row
// of cells, and the write command that the controller broadcasts to it.
// ============================================================================
package cwt_pkg;

   localparam int ENTRIES_DEF  = 64;
   localparam int KEY_BITS_DEF = 32;
   localparam int KEY_PORT_W   = 32;
   localparam int CMD_W        = 64;
   localparam int STAMP_W      = 32;
   localparam int DATA_W       = 32;
   localparam int ADDR_W       = 3;

   // Register selects, taken from the word address bit of the port.
   localparam logic REG_LEADER = 1'b0;
   localparam logic REG_SHARE  = 1'b1;

   typedef enum logic [1:0] {
      REQ_RECORD = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_QUERY  = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_FINISH = 2'd2
   } state_type;

   typedef enum logic [1:0] {
      WOP_NONE  = 2'd0,
      WOP_STORE = 2'd1,
      WOP_CLEAR = 2'd2
   } wop_kind_type;

   // Running summary of the cells that the scan has already passed.
   typedef struct packed {
      logic               any;
      logic               any_write;
      logic               dup_hit;
      logic               free_hit;
      logic               found;
      logic [STAMP_W-1:0] best_age;
      logic [CMD_W-1:0]   best_cmd;
   } acc_type;

   // Write command broadcast to every cell in the finishing cycle.
   typedef struct packed {
      wop_kind_type       op;
      logic               use_dup;
      logic [STAMP_W-1:0] stamp;
   } wop_type;

endpackage

FILE: design/cwt_cell.sv
// ============================================================================
// cwt_cell: one entry of the conflict witness table
// Holds one command and folds it into the scan summary that passes through,
// registering the summary for the next cell along the row.
// ============================================================================
module cwt_cell #(
   parameter int KEY_W = cwt_pkg::KEY_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        link_tok,
   input  cwt_pkg::acc_type            link_acc,
   input  logic [KEY_W-1:0]            req_key,
   input  logic [cwt_pkg::CMD_W-1:0]   req_cmd,
   input  logic                        req_wr,
   input  logic [cwt_pkg::STAMP_W-1:0] stamp_now,
   input  cwt_pkg::wop_type            wop,
   output logic                        tok_out,
   output cwt_pkg::acc_type            acc_out,
   output logic                        valid_out
);

   logic                        valid_ff;
   logic [KEY_W-1:0]            key_ff;
   logic [cwt_pkg::CMD_W-1:0]   cmd_ff;
   logic [cwt_pkg::STAMP_W-1:0] stamp_ff;
   logic                        write_ff;
   logic                        dup_here_ff;
   logic                        free_here_ff;
   logic                        tok_ff;
   cwt_pkg::acc_type            acc_ff;
   cwt_pkg::acc_type            acc_in;

   logic                        key_hit;
   logic                        cmd_hit;
   logic                        take;
   logic                        dup_first;
   logic                        free_first;
   logic                        sel;
   logic [cwt_pkg::STAMP_W-1:0] age;

   always_comb begin
      key_hit    = valid_ff && (key_ff == req_key);
      cmd_hit    = key_hit && (cmd_ff == req_cmd);
      age        = stamp_now - stamp_ff;
      // Strictly greater, so the lowest slot keeps a tie.
      take       = key_hit && (!link_acc.found || (age > link_acc.best_age));
      dup_first  = cmd_hit && !link_acc.dup_hit;
      free_first = !valid_ff && !link_acc.free_hit;

      acc_in           = link_acc;
      acc_in.any       = link_acc.any | key_hit;
      acc_in.any_write = link_acc.any_write | (key_hit & write_ff);
      acc_in.dup_hit   = link_acc.dup_hit | cmd_hit;
      acc_in.free_hit  = link_acc.free_hit | !valid_ff;
      acc_in.found     = link_acc.found | key_hit;
      if (take) begin
         acc_in.best_age = age;
         acc_in.best_cmd = cmd_ff;
      end

      sel = wop.use_dup ? dup_here_ff : free_here_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         tok_ff <= link_tok;
         if ((wop.op == cwt_pkg::WOP_STORE) && sel) begin
            valid_ff <= 1'b1;
         end else if ((wop.op == cwt_pkg::WOP_CLEAR) && dup_here_ff) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (link_tok) begin
         acc_ff       <= acc_in;
         dup_here_ff  <= dup_first;
         free_here_ff <= free_first;
      end
      if ((wop.op == cwt_pkg::WOP_STORE) && sel) begin
         key_ff   <= req_key;
         cmd_ff   <= req_cmd;
         stamp_ff <= wop.stamp;
         write_ff <= req_wr;
      end
   end

   assign tok_out   = tok_ff;
   assign acc_out   = acc_ff;
   assign valid_out = valid_ff;

endmodule

FILE: design/conflict_witness_table_unit.sv
// ============================================================================
// conflict_witness_table_unit: table of outstanding commands with conflict
// checks, removal and oldest-command queries
// A row of ENTRIES cells, each holding one command, scanned by a token.
// ============================================================================
// One request is handled at a time. After acceptance a scan token walks the
// row of cells one cell per cycle, each cell folding its entry into a
// running summary (key match, write present, first exact match, first free
// entry, oldest command on the key), and the finishing state then applies
// the store or the removal and loads the response register. The next
// request can be taken in the same cycle as the response is offered. A new
// request may be accepted while the previous response still waits to be
// taken; the finishing cycle waits for the response register to be free.
// The table needs no clearing after reset: only the per-entry valid bits
// are cleared. Keys are compared on their low KEY_BITS bits (at most the 32
// bits of the key port). Configuration registers, at byte addresses 0
// (leader mode) and 4 (read sharing), must only be written while no request
// is in progress.
module conflict_witness_table_unit #(
   parameter int ENTRIES  = cwt_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = cwt_pkg::KEY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_type,
   input  logic [cwt_pkg::KEY_PORT_W-1:0]    req_key,
   input  logic [cwt_pkg::CMD_W-1:0]         req_cmd_id,
   input  logic                              req_is_write,
   // Response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_accepted,
   output logic                              rsp_removed,
   output logic [cwt_pkg::CMD_W-1:0]         rsp_oldest_cmd_id,
   output logic                              rsp_table_full,
   output logic [$clog2(ENTRIES+1)-1:0]      rsp_entries_held,
   // Configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cwt_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [cwt_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [cwt_pkg::DATA_W-1:0]        csr_prdata,
   output logic                              csr_pready
);

   // Only the low bits of the key port take part when KEY_BITS is smaller.
   localparam int KeyW = (KEY_BITS < cwt_pkg::KEY_PORT_W) ? KEY_BITS : cwt_pkg::KEY_PORT_W;
   localparam int CntW = $clog2(ENTRIES + 1);

   cwt_pkg::state_type          state_ff, state_in;
   cwt_pkg::req_kind_type       kind_ff;
   logic [KeyW-1:0]             key_ff;
   logic [cwt_pkg::CMD_W-1:0]   cmd_ff;
   logic                        wr_ff;
   logic                        start_ff;
   logic [cwt_pkg::STAMP_W-1:0] stamp_ff;
   logic [CntW-1:0]             count_ff, count_in;
   logic                        leader_ff;
   logic                        share_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_accepted_ff;
   logic                        rsp_removed_ff;
   logic [cwt_pkg::CMD_W-1:0]   rsp_oldest_ff;
   logic                        rsp_full_ff;
   logic [CntW-1:0]             rsp_held_ff;

   logic                        req_fire;
   logic                        can_load;
   logic                        finish;
   logic                        csr_write;

   logic                        res_accepted;
   logic                        res_removed;
   logic [cwt_pkg::CMD_W-1:0]   res_oldest;
   logic                        res_full;
   logic                        do_store;
   cwt_pkg::wop_type            wop_calc;
   cwt_pkg::wop_type            wop;
   cwt_pkg::acc_type            end_acc;

   logic                        tok_chain [ENTRIES+1];
   cwt_pkg::acc_type            acc_chain [ENTRIES+1];
   logic [ENTRIES-1:0]          valid_vec;

   // ------------------------------------------------------------------------
   // Configuration registers. Bit 2 of the byte address picks the register.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         leader_ff <= 1'b0;
         share_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            cwt_pkg::REG_LEADER: leader_ff <= csr_pwdata[0];
            cwt_pkg::REG_SHARE:  share_ff  <= csr_pwdata[0];
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         cwt_pkg::REG_LEADER: csr_prdata[0] = leader_ff;
         cwt_pkg::REG_SHARE:  csr_prdata[0] = share_ff;
      endcase
   end

   // ------------------------------------------------------------------------
   // Row of cells. The token enters cell 0 the cycle after acceptance with an
   // empty summary and leaves the last cell after passing each cell's register.
   // ------------------------------------------------------------------------
   assign tok_chain[0] = start_ff;
   assign acc_chain[0] = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      cwt_cell #(
         .KEY_W (KeyW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .link_tok  (tok_chain[g]),
         .link_acc  (acc_chain[g]),
         .req_key   (key_ff),
         .req_cmd   (cmd_ff),
         .req_wr    (wr_ff),
         .stamp_now (stamp_ff),
         .wop       (wop),
         .tok_out   (tok_chain[g+1]),
         .acc_out   (acc_chain[g+1]),
         .valid_out (valid_vec[g])
      );
   end

   assign end_acc = acc_chain[ENTRIES];

   // ------------------------------------------------------------------------
   // Sequencer: idle, scan while the token travels, then finish once the
   // response register can take the result.
   // ------------------------------------------------------------------------
   assign req_ready = (state_ff == cwt_pkg::S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == cwt_pkg::S_FINISH) && can_load;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cwt_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = cwt_pkg::S_SCAN;
            end
         end
         cwt_pkg::S_SCAN: begin
            if (tok_chain[ENTRIES]) begin
               state_in = cwt_pkg::S_FINISH;
            end
         end
         cwt_pkg::S_FINISH: begin
            if (can_load) begin
               state_in = cwt_pkg::S_IDLE;
            end
         end
         default: state_in = cwt_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cwt_pkg::S_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= req_fire;
      end
   end

   // The request is held for the whole scan and the finishing cycle.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= cwt_pkg::req_kind_type'(req_type);
         key_ff  <= req_key[KeyW-1:0];
         cmd_ff  <= req_cmd_id;
         wr_ff   <= req_is_write;
      end
   end

   // ------------------------------------------------------------------------
   // Decision taken from the summary that left the last cell.
   // ------------------------------------------------------------------------
   always_comb begin
      res_accepted     = 1'b0;
      res_removed      = 1'b0;
      res_oldest       = '0;
      res_full         = 1'b0;
      do_store         = 1'b0;
      count_in         = count_ff;
      wop_calc.op      = cwt_pkg::WOP_NONE;
      wop_calc.use_dup = end_acc.dup_hit;
      wop_calc.stamp   = stamp_ff + cwt_pkg::STAMP_W'(1);
      unique case (kind_ff)
         cwt_pkg::REQ_RECORD: begin
            // A read may join pending reads when sharing is enabled.
            res_accepted = !end_acc.any ||
                           (share_ff && !end_acc.any_write && !wr_ff);
            if (res_accepted || leader_ff) begin
               // A duplicate is rewritten in place and never needs room.
               if (end_acc.dup_hit || end_acc.free_hit) begin
                  do_store    = 1'b1;
                  wop_calc.op = cwt_pkg::WOP_STORE;
                  if (!end_acc.dup_hit) begin
                     count_in = count_ff + CntW'(1);
                  end
               end else begin
                  res_full = 1'b1;
               end
            end
         end
         cwt_pkg::REQ_REMOVE: begin
            if (end_acc.dup_hit) begin
               res_removed = 1'b1;
               wop_calc.op = cwt_pkg::WOP_CLEAR;
               count_in    = count_ff - CntW'(1);
            end
         end
         cwt_pkg::REQ_QUERY: begin
            res_oldest = end_acc.found ? end_acc.best_cmd : '1;
         end
         default: begin
            res_oldest = '0;
         end
      endcase

      wop = wop_calc;
      if (!finish) begin
         wop.op = cwt_pkg::WOP_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff <= '0;
         count_ff <= '0;
      end else if (finish) begin
         count_ff <= count_in;
         if (do_store) begin
            stamp_ff <= wop_calc.stamp;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response register.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_accepted_ff <= res_accepted;
         rsp_removed_ff  <= res_removed;
         rsp_oldest_ff   <= res_oldest;
         rsp_full_ff     <= res_full;
         rsp_held_ff     <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_removed       = rsp_removed_ff;
   assign rsp_oldest_cmd_id = rsp_oldest_ff;
   assign rsp_table_full    = rsp_full_ff;
   assign rsp_entries_held  = rsp_held_ff;

`ifndef NO_ASSERTIONS
   // The entry count always agrees with the valid bits held in the cells.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("entry count disagrees with valid entries");

   // The scan token leaves the row only while a scan is in progress.
   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_chain[ENTRIES] |-> (state_ff == cwt_pkg::S_SCAN))
      else $error("scan token left the row outside a scan");

   // The entry count and the stamp change only in the finishing cycle.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !finish |=> (count_ff == $past(count_ff)) && (stamp_ff == $past(stamp_ff)))
      else $error("table state changed outside the finishing cycle");

   // An accepted request starts a scan at once.
   a_fire_scans: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == cwt_pkg::S_SCAN) && start_ff)
      else $error("accepted request did not start a scan");
`endif

endmodule
